// ===== design/clbs_pkg.sv =====
`default_nettype none
package clbs_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TIMER_W  = 8;
  localparam int unsigned BUDGET_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [ACTION_W-1:0]  action_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [TIMER_W-1:0]   timer_t;
  typedef logic [BUDGET_W-1:0]  budget_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // request codes; the spare code behaves as a tick
  localparam action_t ACT_TICK  = 2'd0;
  localparam action_t ACT_INSTR = 2'd1;
  localparam action_t ACT_DATA  = 2'd2;

  // register indexes
  localparam cfg_idx_t CFG_SETUP = 2'd0;
  localparam cfg_idx_t CFG_PULSE = 2'd1;
  localparam cfg_idx_t CFG_BUSY  = 2'd2;

  localparam timer_t  SETUP_RST = 8'd2;
  localparam timer_t  PULSE_RST = 8'd11;
  localparam budget_t BUSY_RST  = 16'd1000;

  localparam int unsigned BUSY_BIT = 7;

  typedef enum logic [8:0] {
    PH_IDLE      = 9'b000000001,
    PH_W_SETUP   = 9'b000000010,
    PH_W_HI      = 9'b000000100,
    PH_W_LO      = 9'b000001000,
    PH_P_SETUP   = 9'b000010000,
    PH_P_HI      = 9'b000100000,
    PH_P_LO_MORE = 9'b001000000,
    PH_P_LO_FREE = 9'b010000000,
    PH_P_LO_TOUT = 9'b100000000
  } phase_t;

endpackage
`default_nettype wire

// ===== design/clbs_in_if.sv =====
`default_nettype none
interface clbs_in_if;
  import clbs_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  byte_t   byte_in;
  byte_t   bus_sample;

  modport source (output valid, action, byte_in, bus_sample, input ready);
  modport sink   (input valid, action, byte_in, bus_sample, output ready);
endinterface
`default_nettype wire

// ===== design/clbs_out_if.sv =====
`default_nettype none
interface clbs_out_if;
  import clbs_pkg::*;

  logic  valid;
  logic  ready;
  logic  pin_e;
  logic  pin_rs;
  logic  pin_rw;
  byte_t bus_out;
  logic  bus_drive;
  logic  ready_res;
  logic  done_res;
  logic  timed_out;

  modport source (output valid, pin_e, pin_rs, pin_rw, bus_out, bus_drive, ready_res,
                  done_res, timed_out, input ready);
  modport sink   (input valid, pin_e, pin_rs, pin_rw, bus_out, bus_drive, ready_res,
                  done_res, timed_out, output ready);
endinterface
`default_nettype wire

// ===== design/char_lcd_bus_sequencer.sv =====
// character-lcd bus sequencer for an 8-bit hd44780-style parallel bus. every input word
// (a tick, or a request to write an instruction or data byte) yields exactly one result
// word carrying the pin levels after that word: e, rs, rw, the driven byte and its drive
// enable, plus ready, done and timeout flags. time moves only on tick words; a write
// request while a sequence runs is dropped. after the write pulse the busy flag is polled
// (bit 7 of bus_sample on the tick that ends e high) up to busy_limit+1 times. one word is
// taken per clock: the phase update is a single pass into the result register, and the
// input side stays ready whenever that register is empty or being emptied in the same
// cycle. configuration is to be written only while idle (not enforced); no read-back.
`default_nettype none
module char_lcd_bus_sequencer (
  input  wire                 clk,
  input  wire                 rst_n,
  clbs_in_if.sink             in_ch,
  clbs_out_if.source          out_ch,
  input  wire                 cfg_we,
  input  wire clbs_pkg::cfg_idx_t  cfg_index,
  input  wire clbs_pkg::cfg_data_t cfg_data
);
  import clbs_pkg::*;

  // configuration registers
  timer_t  setup_ticks_r;
  timer_t  pulse_ticks_r;
  budget_t busy_limit_r;

  // sequencer state
  phase_t  phase_r,       phase_nxt;
  timer_t  tick_timer_r,  tick_timer_nxt;
  budget_t poll_budget_r, poll_budget_nxt;
  byte_t   held_byte_r,   held_byte_nxt;
  logic    held_mode_r,   held_mode_nxt;
  logic    rs_level_r,    rs_level_nxt;

  // result register
  logic    out_valid_r;
  logic    pin_e_r, pin_rs_r, pin_rw_r, bus_drive_r, ready_res_r, done_r, tout_r;
  byte_t   bus_out_r;

  logic    done_nxt, tout_nxt;
  logic    accept;
  logic    is_req;
  timer_t  pulse_len;
  logic    drive_nxt, write_nxt;

  // result slot is free, or its word leaves this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_req      = (in_ch.action == ACT_INSTR) || (in_ch.action == ACT_DATA);
  // zero pulse width counts as one tick
  assign pulse_len   = (pulse_ticks_r == '0) ? timer_t'(1) : pulse_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_ticks_r <= SETUP_RST;
      pulse_ticks_r <= PULSE_RST;
      busy_limit_r  <= BUSY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SETUP: setup_ticks_r <= cfg_data[TIMER_W-1:0];
        CFG_PULSE: pulse_ticks_r <= cfg_data[TIMER_W-1:0];
        CFG_BUSY:  busy_limit_r  <= cfg_data[BUDGET_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    tick_timer_nxt  = tick_timer_r;
    poll_budget_nxt = poll_budget_r;
    held_byte_nxt   = held_byte_r;
    held_mode_nxt   = held_mode_r;
    rs_level_nxt    = rs_level_r;
    done_nxt        = 1'b0;
    tout_nxt        = 1'b0;

    if (is_req) begin
      // request only latched when idle, otherwise dropped
      if (phase_r == PH_IDLE) begin
        held_byte_nxt = in_ch.byte_in;
        held_mode_nxt = (in_ch.action == ACT_DATA);
        rs_level_nxt  = (in_ch.action == ACT_DATA);
        if (setup_ticks_r == '0) begin
          phase_nxt      = PH_W_HI;
          tick_timer_nxt = pulse_len;
        end else begin
          phase_nxt      = PH_W_SETUP;
          tick_timer_nxt = setup_ticks_r;
        end
      end
    end else if (phase_r != PH_IDLE) begin
      if (tick_timer_r > timer_t'(1)) begin
        tick_timer_nxt = tick_timer_r - timer_t'(1);
      end else begin
        tick_timer_nxt = pulse_len;
        unique case (phase_r)
          PH_W_SETUP: phase_nxt = PH_W_HI;
          PH_W_HI:    phase_nxt = PH_W_LO;
          PH_P_SETUP: phase_nxt = PH_P_HI;
          PH_W_LO, PH_P_LO_MORE: begin
            // rs goes low for the status read
            if (phase_r == PH_W_LO) begin
              poll_budget_nxt = busy_limit_r;
            end
            rs_level_nxt = 1'b0;
            if (setup_ticks_r == '0) begin
              phase_nxt = PH_P_HI;
            end else begin
              phase_nxt      = PH_P_SETUP;
              tick_timer_nxt = setup_ticks_r;
            end
          end
          PH_P_HI: begin
            // busy flag sampled as e-high ends
            if (!in_ch.bus_sample[BUSY_BIT]) begin
              phase_nxt = PH_P_LO_FREE;
            end else if (poll_budget_r == '0) begin
              phase_nxt = PH_P_LO_TOUT;
            end else begin
              poll_budget_nxt = poll_budget_r - budget_t'(1);
              phase_nxt       = PH_P_LO_MORE;
            end
          end
          PH_P_LO_FREE, PH_P_LO_TOUT: begin
            rs_level_nxt   = 1'b1;
            done_nxt       = 1'b1;
            tout_nxt       = (phase_r == PH_P_LO_TOUT);
            phase_nxt      = PH_IDLE;
            tick_timer_nxt = '0;
          end
          default: begin
            phase_nxt      = PH_IDLE;
            tick_timer_nxt = '0;
          end
        endcase
      end
    end
  end

  assign drive_nxt = (phase_nxt == PH_W_HI) || (phase_nxt == PH_W_LO);
  assign write_nxt = (phase_nxt == PH_W_SETUP) || drive_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_timer_r  <= '0;
      poll_budget_r <= '0;
      held_byte_r   <= '0;
      held_mode_r   <= 1'b0;
      rs_level_r    <= 1'b1;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      tick_timer_r  <= tick_timer_nxt;
      poll_budget_r <= poll_budget_nxt;
      held_byte_r   <= held_byte_nxt;
      held_mode_r   <= held_mode_nxt;
      rs_level_r    <= rs_level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with each accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      pin_e_r     <= (phase_nxt == PH_W_HI) || (phase_nxt == PH_P_HI);
      pin_rs_r    <= rs_level_nxt;
      pin_rw_r    <= !write_nxt;
      bus_out_r   <= drive_nxt ? held_byte_nxt : '0;
      bus_drive_r <= drive_nxt;
      ready_res_r <= (phase_nxt == PH_IDLE);
      done_r      <= done_nxt;
      tout_r      <= tout_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pin_e     = pin_e_r;
  assign out_ch.pin_rs    = pin_rs_r;
  assign out_ch.pin_rw    = pin_rw_r;
  assign out_ch.bus_out   = bus_out_r;
  assign out_ch.bus_drive = bus_drive_r;
  assign out_ch.ready_res = ready_res_r;
  assign out_ch.done_res  = done_r;
  assign out_ch.timed_out = tout_r;

`ifndef NO_ASSERTIONS
  // a finished sequence always leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> out_ch.ready_res)
    else $error("done without idle");

  // timeout only reported together with done
  a_tout_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.timed_out |-> out_ch.done_res)
    else $error("timeout without done");

  // data lines only driven during a write
  a_drive_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bus_drive |-> !out_ch.pin_rw)
    else $error("bus driven while reading");

  // held result word is not overwritten while stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !accept)
    else $error("result overrun");
`endif

endmodule
`default_nettype wire

// ===== tb/lcd_seq_checker.sv =====
`timescale 1ns / 100ps
module lcd_seq_checker
  import clbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  clbs_in_if        in_mon,
  clbs_out_if       out_mon,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  cfg_data_t cfg_data,
  output int        errors,
  output int        in_flight,
  output logic      seq_idle,
  output int        results,
  output int        dones,
  output int        timeouts
);

  typedef struct packed {
    logic  e;
    logic  rs;
    logic  rw;
    byte_t bus;
    logic  drive;
    logic  rdy;
    logic  done;
    logic  tout;
  } pins_t;

  // timing registers as last written
  timer_t  setup_len = SETUP_RST;
  timer_t  pulse_cfg = PULSE_RST;
  budget_t busy_cfg  = BUSY_RST;

  // sequencer state
  phase_t  ph        = PH_IDLE;
  timer_t  tmr       = '0;
  budget_t budget    = '0;
  byte_t   held_byte = '0;
  logic    held_data = 1'b0;
  logic    rs_q      = 1'b1;

  pins_t pins_due[$];
  int    n_err  = 0;
  int    n_res  = 0;
  int    n_done = 0;
  int    n_tout = 0;

  task automatic report(input string what, input int got, input int want);
    n_err++;
    if (n_err <= 30)
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // a zero pulse length counts as one tick
  function automatic timer_t pulse_len();
    return (pulse_cfg == '0) ? timer_t'(1) : pulse_cfg;
  endfunction

  function automatic void go(input phase_t p, input timer_t t);
    ph  = p;
    tmr = t;
  endfunction

  function automatic void begin_poll_read();
    rs_q = 1'b0;
    if (setup_len == '0) go(PH_P_HI, pulse_len());
    else go(PH_P_SETUP, setup_len);
  endfunction

  // pin levels after one word, advancing the sequencer state
  function automatic pins_t next_pins(input action_t act, input byte_t b, input byte_t smp);
    pins_t r;
    r = '0;
    if (act == ACT_INSTR || act == ACT_DATA) begin
      if (ph == PH_IDLE) begin
        held_byte = b;
        held_data = (act == ACT_DATA);
        rs_q      = held_data;
        if (setup_len == '0) go(PH_W_HI, pulse_len());
        else go(PH_W_SETUP, setup_len);
      end
    end else if (ph != PH_IDLE) begin
      if (tmr > timer_t'(1)) begin
        tmr = tmr - timer_t'(1);
      end else begin
        tmr = '0;
        case (ph)
          PH_W_SETUP: go(PH_W_HI, pulse_len());
          PH_W_HI:    go(PH_W_LO, pulse_len());
          PH_W_LO: begin
            rs_q   = 1'b1;
            budget = busy_cfg;
            begin_poll_read();
          end
          PH_P_SETUP: go(PH_P_HI, pulse_len());
          PH_P_HI: begin
            if (!smp[BUSY_BIT]) begin
              go(PH_P_LO_FREE, pulse_len());
            end else if (budget == '0) begin
              go(PH_P_LO_TOUT, pulse_len());
            end else begin
              budget = budget - budget_t'(1);
              go(PH_P_LO_MORE, pulse_len());
            end
          end
          PH_P_LO_MORE: begin
            rs_q = 1'b1;
            begin_poll_read();
          end
          PH_P_LO_FREE, PH_P_LO_TOUT: begin
            rs_q   = 1'b1;
            r.done = 1'b1;
            r.tout = (ph == PH_P_LO_TOUT);
            go(PH_IDLE, '0);
          end
          default: go(PH_IDLE, '0);
        endcase
      end
    end
    r.e     = (ph == PH_W_HI || ph == PH_P_HI);
    r.drive = (ph == PH_W_HI || ph == PH_W_LO);
    r.rw    = !(ph == PH_W_SETUP || r.drive);
    r.rs    = rs_q;
    r.bus   = r.drive ? held_byte : '0;
    r.rdy   = (ph == PH_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    pins_t want;
    pins_t got;
    if (!rst_n) begin
      setup_len = SETUP_RST;
      pulse_cfg = PULSE_RST;
      busy_cfg  = BUSY_RST;
      ph        = PH_IDLE;
      tmr       = '0;
      budget    = '0;
      held_byte = '0;
      held_data = 1'b0;
      rs_q      = 1'b1;
      pins_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SETUP: setup_len = cfg_data[TIMER_W-1:0];
          CFG_PULSE: pulse_cfg = cfg_data[TIMER_W-1:0];
          CFG_BUSY:  busy_cfg  = cfg_data[BUDGET_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        pins_due.push_back(next_pins(in_mon.action, in_mon.byte_in, in_mon.bus_sample));
      if (out_mon.valid && out_mon.ready) begin
        n_res++;
        got.e     = out_mon.pin_e;
        got.rs    = out_mon.pin_rs;
        got.rw    = out_mon.pin_rw;
        got.bus   = out_mon.bus_out;
        got.drive = out_mon.bus_drive;
        got.rdy   = out_mon.ready_res;
        got.done  = out_mon.done_res;
        got.tout  = out_mon.timed_out;
        if (pins_due.size() == 0) begin
          report("unexpected result word", int'(got), 0);
        end else begin
          want = pins_due.pop_front();
          if (want.done) n_done++;
          if (want.tout) n_tout++;
          if (got.e !== want.e)         report("pin_e", got.e, want.e);
          if (got.rs !== want.rs)       report("pin_rs", got.rs, want.rs);
          if (got.rw !== want.rw)       report("pin_rw", got.rw, want.rw);
          if (got.bus !== want.bus)     report("bus_out", got.bus, want.bus);
          if (got.drive !== want.drive) report("bus_drive", got.drive, want.drive);
          if (got.rdy !== want.rdy)     report("ready_res", got.rdy, want.rdy);
          if (got.done !== want.done)   report("done_res", got.done, want.done);
          if (got.tout !== want.tout)   report("timed_out", got.tout, want.tout);
        end
      end
    end
    errors    <= n_err;
    in_flight <= pins_due.size();
    seq_idle  <= (ph == PH_IDLE);
    results   <= n_res;
    dones     <= n_done;
    timeouts  <= n_tout;
  end

endmodule

// ===== tb/tb_char_lcd_bus_sequencer.sv =====
`timescale 1ns / 100ps
module tb_char_lcd_bus_sequencer;
  import clbs_pkg::*;

  // spare request code and spare register index, both outside the named sets
  localparam action_t  ACT_SPARE = 2'd3;
  localparam cfg_idx_t CFG_SPARE = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  // idling switches: gaps on the sending side, stalls on the receiving side
  bit   gaps_on   = 1'b0;
  logic stalls_on = 1'b0;

  int   errors;
  int   in_flight;
  logic seq_idle;
  int   results;
  int   dones;
  int   timeouts;
  int   n_settings = 0;

  clbs_in_if  in_ch ();
  clbs_out_if out_ch ();

  char_lcd_bus_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcd_seq_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .in_flight (in_flight),
    .seq_idle  (seq_idle),
    .results   (results),
    .dones     (dones),
    .timeouts  (timeouts)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #(20_000_000);
    $display("FAIL char_lcd_bus_sequencer");
    $finish;
  end

  // receiving side: random stall bursts while enabled
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one word, with an optional gap in front; returns at the accepting edge
  task automatic send_word(input action_t act, input byte_t b, input byte_t smp);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.byte_in    <= b;
    in_ch.bus_sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // tick with a free busy flag until the sequencer is idle, then let results drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (!seq_idle) begin
      send_word(ACT_TICK, byte_t'($urandom), 8'h00);
      // one clear cycle so the idle flag reflects the word just taken
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    while (in_flight != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write all three timing registers back to back, upper data bits of the timer writes as noise
  task automatic program_timing(input timer_t st, input timer_t pl, input budget_t bl,
                                input bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SETUP;
    cfg_data  <= {8'($urandom), st};
    @(posedge clk);
    cfg_index <= CFG_PULSE;
    cfg_data  <= {8'($urandom), pl};
    @(posedge clk);
    cfg_index <= CFG_BUSY;
    cfg_data  <= bl;
    @(posedge clk);
    if (poke_spare) begin
      // unused index, must leave every register alone
      cfg_index <= CFG_SPARE;
      cfg_data  <= cfg_data_t'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // a request to start a sequence, then mostly ticks; requests landing mid-sequence
  // are dropped by the block and act as noise
  task automatic run_traffic(input int n_words, input int busy_pct, input int req_pct);
    int      roll;
    action_t act;
    byte_t   smp;
    send_word($urandom_range(0, 1) ? ACT_DATA : ACT_INSTR, byte_t'($urandom), 8'h00);
    repeat (n_words) begin
      roll = $urandom_range(0, 99);
      smp  = byte_t'($urandom);
      smp[BUSY_BIT] = ($urandom_range(0, 99) < busy_pct);
      if (roll < req_pct)
        act = $urandom_range(0, 1) ? ACT_DATA : ACT_INSTR;
      else if (roll < req_pct + 4)
        act = ACT_SPARE;
      else
        act = ACT_TICK;
      send_word(act, byte_t'($urandom), smp);
    end
  endtask

  initial begin
    timer_t  st;
    timer_t  pl;
    budget_t bl;
    int      n;
    int      busy_pct;
    bit      tail;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_SETUP;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_TICK;
    in_ch.byte_in    <= '0;
    in_ch.bus_sample <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing values: one instruction write and a stretch of ticks
    gaps_on   = 1'b1;
    stalls_on <= 1'b1;
    send_word(ACT_INSTR, 8'h38, 8'h00);
    repeat (60) send_word(ACT_TICK, byte_t'($urandom), $urandom_range(0, 1) ? 8'h80 : 8'h00);
    settle();

    // directed: zero setup, zero pulse, one spare busy read
    gaps_on   = 1'b0;
    stalls_on <= 1'b0;
    program_timing('0, '0, budget_t'(1), 1'b1);
    send_word(ACT_INSTR, 8'hff, 8'h00);    // e rises on the request word itself
    send_word(ACT_DATA, 8'h00, 8'h80);     // dropped, sequence already running
    send_word(ACT_SPARE, 8'h5a, 8'h80);    // spare code counts as a tick
    repeat (6) send_word(ACT_TICK, 8'ha5, 8'hff);  // busy on every read, runs out of budget
    send_word(ACT_DATA, 8'h00, 8'hff);
    repeat (4) send_word(ACT_TICK, 8'hff, 8'h7f);  // not busy, finishes after one read
    send_word(ACT_INSTR, 8'h01, 8'h00);
    repeat (2) send_word(ACT_TICK, 8'h00, 8'h80);
    settle();

    // random phases, each with its own timing; the last two run without idling
    for (int p = 0; p < 12; p++) begin
      tail = (p >= 10);
      st = timer_t'($urandom_range(0, 3));
      pl = timer_t'($urandom_range(0, 3));
      bl = budget_t'($urandom_range(0, 4));
      n  = 60;
      case (p)
        3: begin
          // longest setup and the largest budget
          st = '1;
          pl = timer_t'(2);
          bl = '1;
          n  = 60;
        end
        6: begin
          st = '0;
          pl = timer_t'(1);
          bl = '0;
        end
        9: bl = budget_t'($urandom);
        default: ;
      endcase
      busy_pct  = $urandom_range(0, 2) * 42;
      gaps_on   = !tail && ($urandom_range(0, 3) != 0);
      stalls_on <= !tail && ($urandom_range(0, 3) != 0);
      program_timing(st, pl, bl, $urandom_range(0, 1));
      run_traffic(n, busy_pct, $urandom_range(3, 15));
      settle();
    end

    in_ch.valid <= 1'b0;
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("checked %0d result words over %0d timing settings", results, n_settings);
    $display("%0d write sequences completed, %0d of them on busy timeout", dones, timeouts);
    if (errors == 0 && in_flight == 0) begin
      $display("PASS char_lcd_bus_sequencer");
    end else begin
      $display("FAIL char_lcd_bus_sequencer");
    end
    $finish;
  end

endmodule
